@@ hw/rtl/onb_from_one_axis_defines.svh @@
// ----------------------------------------------------------------------------
// onb_from_one_axis_defines.svh
// Assertion macros shared by the orthonormal basis block.
// ----------------------------------------------------------------------------
`ifndef ONB_FROM_ONE_AXIS_DEFINES_SVH
`define ONB_FROM_ONE_AXIS_DEFINES_SVH

// condition must never hold outside reset
`define ONB_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ONB_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/onb_pkg.sv @@
// ----------------------------------------------------------------------------
// onb_pkg
// Types and constants for the orthonormal basis pipeline.
// ----------------------------------------------------------------------------
package onb_pkg;

	localparam int COMP_W    = 16;
	localparam int NSTEP     = 15;              // result bits per normalised component
	localparam int ACC_W     = 66;              // remainder / partial product width
	localparam int SUM_W     = 34;              // sum of three squares
	localparam int NORM_LAT  = NSTEP + 2;       // squares, sum, one stage per bit
	localparam int CROSS_LAT = 2;
	localparam int PIPE_LAT  = 2 * NORM_LAT + 2 + CROSS_LAT + 1;

	localparam logic signed [COMP_W-1:0] ONE_Q14 = 16'sd16384;
	localparam logic [15:0] THR_RESET = 16'd655;

	typedef enum logic [1:0] {
		AXIS_U = 2'd0,
		AXIS_V = 2'd1,
		AXIS_W = 2'd2,
		AXIS_X = 2'd3
	} axis_e;

	typedef logic signed [COMP_W-1:0] comp_t;
	typedef comp_t [2:0] vec3_t;

	typedef struct packed {
		logic [1:0]         func;
		logic signed [15:0] in_x;
		logic signed [15:0] in_y;
		logic signed [15:0] in_z;
	} cmd_t;

	typedef struct packed {
		logic signed [15:0] u_x;
		logic signed [15:0] u_y;
		logic signed [15:0] u_z;
		logic signed [15:0] v_x;
		logic signed [15:0] v_y;
		logic signed [15:0] v_z;
		logic signed [15:0] w_x;
		logic signed [15:0] w_y;
		logic signed [15:0] w_z;
		logic               degenerate;
	} result_t;

	// travels beside the arithmetic
	typedef struct packed {
		logic [1:0] func;
		logic       degen;
		vec3_t      n;
	} side_t;

endpackage

@@ hw/rtl/onb_norm.sv @@
// ----------------------------------------------------------------------------
// onb_norm
// Pipelined exact normalisation of a 3-vector to Q1.14, one bit per stage.
// ----------------------------------------------------------------------------
module onb_norm import onb_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  vec3_t in_vec,
	output logic  out_valid,
	output vec3_t out_vec
);

	// stage 1: magnitudes and squares
	logic             valid_s1;
	logic [31:0]      sq_s1 [3];
	logic [2:0]       neg_s1;
	logic [COMP_W:0]  mag [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag[i] = in_vec[i][COMP_W-1] ? (COMP_W+1)'(-$signed({in_vec[i][COMP_W-1], in_vec[i]}))
				: {1'b0, in_vec[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sq_s1[i]  <= 32'(mag[i] * mag[i]);
			neg_s1[i] <= in_vec[i][COMP_W-1];
		end
	end

	// iteration state; index 0 is the sum stage
	logic                    vld_it  [NSTEP+1];
	logic [SUM_W-1:0]        s_it    [NSTEP+1];
	logic                    zero_it [NSTEP+1];
	logic [2:0]              neg_it  [NSTEP+1];
	logic signed [ACC_W-1:0] d_it    [NSTEP+1][3];
	logic signed [ACC_W-1:0] p_it    [NSTEP+1][3];
	logic [NSTEP-1:0]        q_it    [NSTEP+1][3];

	// stage 2: sum of squares, remainder = m^2 * 2^30 - s, partial = -s
	logic [SUM_W-1:0] sum;
	assign sum = SUM_W'(sq_s1[0]) + SUM_W'(sq_s1[1]) + SUM_W'(sq_s1[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_it[0] <= 1'b0;
		end else begin
			vld_it[0] <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		s_it[0]    <= sum;
		zero_it[0] <= (sum == '0);
		neg_it[0]  <= neg_s1;
		for (int i = 0; i < 3; i++) begin
			d_it[0][i] <= ($signed({{(ACC_W-32){1'b0}}, sq_s1[i]}) <<< 30)
				- $signed({{(ACC_W-SUM_W){1'b0}}, sum});
			p_it[0][i] <= -$signed({{(ACC_W-SUM_W){1'b0}}, sum});
			q_it[0][i] <= '0;
		end
	end

	// one result bit per stage: keep bit if (2t-1)^2 * s <= m^2 * 2^30
	for (genvar k = 0; k < NSTEP; k++) begin : g_step
		localparam int B = NSTEP - 1 - k;
		logic signed [ACC_W-1:0] s_ext;
		logic signed [ACC_W-1:0] cand [3];

		assign s_ext = $signed({{(ACC_W-SUM_W){1'b0}}, s_it[k]});

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				cand[i] = d_it[k][i] - ((p_it[k][i] <<< (B + 2)) + (s_ext <<< (2 * B + 2)));
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_it[k+1] <= 1'b0;
			end else begin
				vld_it[k+1] <= vld_it[k];
			end
		end

		always_ff @(posedge clk) begin
			s_it[k+1]    <= s_it[k];
			zero_it[k+1] <= zero_it[k];
			neg_it[k+1]  <= neg_it[k];
			for (int i = 0; i < 3; i++) begin
				if (!cand[i][ACC_W-1]) begin
					d_it[k+1][i] <= cand[i];
					p_it[k+1][i] <= p_it[k][i] + (s_ext <<< (B + 1));
					q_it[k+1][i] <= q_it[k][i] | (NSTEP'(1) << B);
				end else begin
					d_it[k+1][i] <= d_it[k][i];
					p_it[k+1][i] <= p_it[k][i];
					q_it[k+1][i] <= q_it[k][i];
				end
			end
		end
	end

	// restore sign; a zero vector gives zeros
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (zero_it[NSTEP]) begin
				out_vec[i] = '0;
			end else if (neg_it[NSTEP][i]) begin
				out_vec[i] = -$signed({1'b0, q_it[NSTEP][i]});
			end else begin
				out_vec[i] = $signed({1'b0, q_it[NSTEP][i]});
			end
		end
	end

	assign out_valid = vld_it[NSTEP];

endmodule

@@ hw/rtl/onb_cross.sv @@
// ----------------------------------------------------------------------------
// onb_cross
// Two-stage Q1.14 cross product, rounded half up and saturated to +-1.
// ----------------------------------------------------------------------------
module onb_cross import onb_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  vec3_t a,
	input  vec3_t b,
	output logic  out_valid,
	output vec3_t out_vec
);

	// stage 1: six products
	logic               valid_s1;
	logic signed [31:0] pa_s1 [3];
	logic signed [31:0] pb_s1 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			valid_s1  <= in_valid;
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		pa_s1[0] <= a[1] * b[2];
		pb_s1[0] <= a[2] * b[1];
		pa_s1[1] <= a[2] * b[0];
		pb_s1[1] <= a[0] * b[2];
		pa_s1[2] <= a[0] * b[1];
		pb_s1[2] <= a[1] * b[0];
	end

	// stage 2: difference, round, saturate
	logic signed [33:0] biased [3];
	logic signed [19:0] rnd    [3];
	comp_t              sat    [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			biased[i] = 34'(pa_s1[i]) - 34'(pb_s1[i]) + 34'sd8192;
			rnd[i]    = 20'(biased[i] >>> 14);
			if (rnd[i] > 20'(ONE_Q14)) begin
				sat[i] = ONE_Q14;
			end else if (rnd[i] < -20'(ONE_Q14)) begin
				sat[i] = -ONE_Q14;
			end else begin
				sat[i] = COMP_W'(rnd[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			out_vec[i] <= sat[i];
		end
	end

endmodule

@@ hw/rtl/onb_from_one_axis.sv @@
// ----------------------------------------------------------------------------
// onb_from_one_axis
// Right-handed orthonormal basis from one vector, Q1.14 results.
// ----------------------------------------------------------------------------
// Fully pipelined: one item may be started every clock, busy is never raised,
// and each result appears on result with done, in the order of the starts.
// Each item passes through the two bit-per-stage normalisers
// (17 stages each), perpendicular selection, the cross product and the
// output register. done is a one-cycle strobe and cannot be held off, so
// results must be taken when shown. fallback_threshold is written through
// cfg_* and should only change while no item is in flight.
module onb_from_one_axis import onb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  cmd_t        cmd,
	output logic        done,
	output result_t     result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	`include "onb_from_one_axis_defines.svh"

	// threshold register
	logic [15:0] thr_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			thr_q <= cfg_data;
		end
	end

	// first normaliser
	logic  in_go;
	vec3_t in_vec;
	logic  n1_valid;
	vec3_t n1_vec;

	assign in_go  = start && !busy;
	assign in_vec = {cmd.in_z, cmd.in_y, cmd.in_x};

	onb_norm u_norm_a (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_go),
		.in_vec   (in_vec),
		.out_valid(n1_valid),
		.out_vec  (n1_vec)
	);

	// selector and zero flag alongside the first normaliser
	side_t side1 [NORM_LAT+1];

	always_comb begin
		side1[0].func  = cmd.func;
		side1[0].degen = (cmd.in_x == '0) && (cmd.in_y == '0) && (cmd.in_z == '0);
		side1[0].n     = '0;
	end

	for (genvar k = 0; k < NORM_LAT; k++) begin : g_side1
		always_ff @(posedge clk) begin
			side1[k+1] <= side1[k];
		end
	end

	// fallback stage 1: squares of n_y and n_z
	logic        valid_f1_s1;
	side_t       side_s1;
	logic [28:0] sqy_s1, sqz_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_f1_s1 <= 1'b0;
		end else begin
			valid_f1_s1 <= n1_valid;
		end
	end

	always_ff @(posedge clk) begin
		side_s1.func  <= side1[NORM_LAT].func;
		side_s1.degen <= side1[NORM_LAT].degen;
		side_s1.n     <= n1_vec;
		sqy_s1        <= 29'(n1_vec[1] * n1_vec[1]);
		sqz_s1        <= 29'(n1_vec[2] * n1_vec[2]);
	end

	// fallback stage 2: compare and form the perpendicular
	logic  valid_f2_s2;
	side_t side_s2;
	vec3_t perp_s2;
	logic  fall;

	assign fall = (30'(sqy_s1) + 30'(sqz_s1)) < {2'b00, thr_q, 12'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_f2_s2 <= 1'b0;
		end else begin
			valid_f2_s2 <= valid_f1_s1;
		end
	end

	always_ff @(posedge clk) begin
		side_s2 <= side_s1;
		if (fall) begin
			perp_s2 <= {side_s1.n[0], comp_t'(0), comp_t'(-side_s1.n[2])};
		end else begin
			perp_s2 <= {comp_t'(-side_s1.n[1]), side_s1.n[2], comp_t'(0)};
		end
	end

	// second normaliser
	logic  n2_valid;
	vec3_t n2_vec;

	onb_norm u_norm_b (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_f2_s2),
		.in_vec   (perp_s2),
		.out_valid(n2_valid),
		.out_vec  (n2_vec)
	);

	side_t side2 [NORM_LAT+1];

	assign side2[0] = side_s2;

	for (genvar k = 0; k < NORM_LAT; k++) begin : g_side2
		always_ff @(posedge clk) begin
			side2[k+1] <= side2[k];
		end
	end

	// cross product; v as the given axis swaps the operands
	vec3_t cx_a, cx_b;
	logic  cx_valid;
	vec3_t cx_vec;

	always_comb begin
		if (side2[NORM_LAT].func == AXIS_V) begin
			cx_a = n2_vec;
			cx_b = side2[NORM_LAT].n;
		end else begin
			cx_a = side2[NORM_LAT].n;
			cx_b = n2_vec;
		end
	end

	onb_cross u_cross (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (n2_valid),
		.a        (cx_a),
		.b        (cx_b),
		.out_valid(cx_valid),
		.out_vec  (cx_vec)
	);

	// keep selector, n and perpendicular beside the cross product
	side_t side_c [CROSS_LAT+1];
	vec3_t perp_c [CROSS_LAT+1];

	assign side_c[0] = side2[NORM_LAT];
	assign perp_c[0] = n2_vec;

	for (genvar k = 0; k < CROSS_LAT; k++) begin : g_side_c
		always_ff @(posedge clk) begin
			side_c[k+1] <= side_c[k];
			perp_c[k+1] <= perp_c[k];
		end
	end

	// output register: place axes by selector
	vec3_t ax_u, ax_v, ax_w;
	side_t sd;
	vec3_t pn;

	assign sd = side_c[CROSS_LAT];
	assign pn = perp_c[CROSS_LAT];

	always_comb begin
		case (axis_e'(sd.func))
			AXIS_U: begin
				ax_u = sd.n;
				ax_v = pn;
				ax_w = cx_vec;
			end
			AXIS_V: begin
				ax_u = pn;
				ax_v = sd.n;
				ax_w = cx_vec;
			end
			default: begin
				ax_u = pn;
				ax_v = cx_vec;
				ax_w = sd.n;
			end
		endcase
		if (sd.degen) begin
			ax_u = '0;
			ax_v = '0;
			ax_w = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cx_valid;
		end
	end

	always_ff @(posedge clk) begin
		result <= {ax_u[0], ax_u[1], ax_u[2], ax_v[0], ax_v[1], ax_v[2],
			ax_w[0], ax_w[1], ax_w[2], sd.degen};
	end

	// checks
	`ONB_ASSERT_IMPL(a_done_follows_start, done, $past(start, PIPE_LAT), "result without a started item")
	`ONB_ASSERT_IMPL(a_degen_zero, done && result.degenerate, (result.u_x == '0) && (result.v_y == '0) && (result.w_z == '0), "degenerate result not zero")
	`ONB_ASSERT_NEVER(a_u_range, done && ((result.u_x > ONE_Q14) || (result.u_x < -ONE_Q14)), "u_x out of range")

endmodule

@@ sim/onb_basis_checker.sv @@
// ----------------------------------------------------------------------------
// onb_basis_checker
// Watches the command, result and threshold channels of the basis block,
// predicts each basis in exact integer arithmetic and compares field by field.
// ----------------------------------------------------------------------------
module onb_basis_checker import onb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  cmd_t        cmd,
	input  logic        done,
	input  result_t     result,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [15:0] cfg_data,
	output int          fail_count,
	output int          pending
);

	logic [15:0] threshold;
	result_t     basis_q[$];

	// rounded normalisation to Q1.14, ties away from zero, exact
	function automatic void unit_vec(input longint a[3], output longint r[3]);
		longint unsigned s, m, rhs, q, t, d;
		s = 0;
		for (int i = 0; i < 3; i++)
			s += longint'(a[i] * a[i]);
		for (int i = 0; i < 3; i++) begin
			m = (a[i] < 0) ? -a[i] : a[i];
			rhs = (m * m) << 30;
			q = 0;
			if (s != 0) begin
				for (int b = 14; b >= 0; b--) begin
					t = q | (64'd1 << b);
					d = 2 * t - 1;
					if (t <= 16384 && d * d * s <= rhs)
						q = t;
				end
			end
			r[i] = (a[i] < 0) ? -longint'(q) : longint'(q);
		end
	endfunction

	// Q2.28 to Q1.14, ties toward plus infinity, saturated
	function automatic longint to_q14(input longint s);
		longint q;
		q = (s + 8192) >>> 14;
		if (q > 16384) q = 16384;
		if (q < -16384) q = -16384;
		return q;
	endfunction

	function automatic void cross3(input longint a[3], input longint b[3],
			output longint r[3]);
		r[0] = to_q14(a[1] * b[2] - a[2] * b[1]);
		r[1] = to_q14(a[2] * b[0] - a[0] * b[2]);
		r[2] = to_q14(a[0] * b[1] - a[1] * b[0]);
	endfunction

	function automatic result_t predict_basis(input cmd_t c, input logic [15:0] thr);
		longint a[3], n[3], p[3], pn[3], t[3];
		longint ax0[3], ax1[3], ax2[3];
		result_t r;
		a[0] = c.in_x;
		a[1] = c.in_y;
		a[2] = c.in_z;
		r = '0;
		if (a[0] == 0 && a[1] == 0 && a[2] == 0) begin
			r.degenerate = 1'b1;
			return r;
		end
		unit_vec(a, n);
		// fall back to the y axis when the x cross product is too short
		if (n[1] * n[1] + n[2] * n[2] < (longint'(thr) << 12)) begin
			p[0] = -n[2]; p[1] = 0; p[2] = n[0];
		end else begin
			p[0] = 0; p[1] = n[2]; p[2] = -n[1];
		end
		unit_vec(p, pn);
		case (axis_e'(c.func))
			AXIS_U: begin
				cross3(n, pn, t);
				ax0 = n; ax1 = pn; ax2 = t;
			end
			AXIS_V: begin
				cross3(pn, n, t);
				ax0 = pn; ax1 = n; ax2 = t;
			end
			default: begin
				cross3(n, pn, t);
				ax0 = pn; ax1 = t; ax2 = n;
			end
		endcase
		r.u_x = 16'(ax0[0]); r.u_y = 16'(ax0[1]); r.u_z = 16'(ax0[2]);
		r.v_x = 16'(ax1[0]); r.v_y = 16'(ax1[1]); r.v_z = 16'(ax1[2]);
		r.w_x = 16'(ax2[0]); r.w_y = 16'(ax2[1]); r.w_z = 16'(ax2[2]);
		return r;
	endfunction

	task automatic cmp_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	assign pending = basis_q.size();

	// predict on accepted items, compare on results
	always @(posedge clk or negedge arst_n) begin
		result_t e;
		if (!arst_n) begin
			threshold  <= THR_RESET;
			fail_count = 0;
			basis_q.delete();
		end else begin
			if (cfg_valid && cfg_ready)
				threshold <= cfg_data;
			if (start && !busy)
				basis_q.push_back(predict_basis(cmd, threshold));
			if (done) begin
				if (basis_q.size() == 0) begin
					$error("result with no item outstanding");
					fail_count++;
				end else begin
					e = basis_q.pop_front();
					cmp_field("u_x", e.u_x, result.u_x);
					cmp_field("u_y", e.u_y, result.u_y);
					cmp_field("u_z", e.u_z, result.u_z);
					cmp_field("v_x", e.v_x, result.v_x);
					cmp_field("v_y", e.v_y, result.v_y);
					cmp_field("v_z", e.v_z, result.v_z);
					cmp_field("w_x", e.w_x, result.w_x);
					cmp_field("w_y", e.w_y, result.w_y);
					cmp_field("w_z", e.w_z, result.w_z);
					cmp_field("degenerate", e.degenerate, result.degenerate);
				end
			end
		end
	end

endmodule

@@ sim/tb_onb_from_one_axis.sv @@
// ----------------------------------------------------------------------------
// tb_onb_from_one_axis
// Stimulus and verdict for the basis block: directed corner vectors, then
// random vectors under several fallback thresholds with random gaps.
// ----------------------------------------------------------------------------
module tb_onb_from_one_axis;
	import onb_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	cmd_t        cmd;
	logic        done;
	result_t     result;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;
	int          fail_count;
	int          pending;
	int          n_items;
	int          n_thr;

	onb_from_one_axis DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .result(result), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	onb_basis_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .result(result), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// watchdog
	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

	// gap after an item: mostly none or short, now and then long
	task automatic idle_gap();
		int g, k;
		k = $urandom_range(0, 99);
		g = (k < 45) ? 0 : (k < 92) ? $urandom_range(1, 3) : $urandom_range(8, 60);
		repeat (g) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	task automatic send_vec(input axis_e f, input int x, input int y, input int z);
		@(negedge clk);
		start <= 1'b1;
		cmd   <= '{func: f, in_x: x[15:0], in_y: y[15:0], in_z: z[15:0]};
		do @(posedge clk); while (busy);
		n_items++;
		idle_gap();
	endtask

	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (PIPE_LAT + 4) @(posedge clk);
	endtask

	task automatic write_thr(input logic [15:0] v);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		n_thr++;
	endtask

	function automatic int rnd_comp();
		int k;
		k = $urandom_range(0, 9);
		if (k < 5) return $signed($urandom_range(0, 65535)) - 32768;
		if (k < 8) return $signed($urandom_range(0, 64)) - 32;
		return (k == 8) ? 32767 : -32768;
	endfunction

	// random phase: general vectors plus vectors close to the x axis
	task automatic random_phase(input int count);
		int x, y, z;
		for (int i = 0; i < count; i++) begin
			x = rnd_comp();
			y = rnd_comp();
			z = rnd_comp();
			if ($urandom_range(0, 3) == 0) begin
				x = ($urandom_range(0, 1) ? 1 : -1) * $urandom_range(1000, 32767);
				y = $signed($urandom_range(0, 600)) - 300;
				z = $signed($urandom_range(0, 600)) - 300;
			end
			send_vec(axis_e'($urandom_range(0, 3)), x, y, z);
			if (i == count / 2) drain();
		end
	endtask

	initial begin
		start     = 1'b0;
		cmd       = '0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		n_items   = 0;
		n_thr     = 0;
		arst_n    = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed corners under the reset threshold
		send_vec(AXIS_U, 0, 0, 0);
		send_vec(AXIS_U, 1, 0, 0);
		send_vec(AXIS_V, 0, 1, 0);
		send_vec(AXIS_W, 0, 0, 1);
		send_vec(AXIS_X, 0, 0, -1);
		send_vec(AXIS_U, 32767, 32767, 32767);
		send_vec(AXIS_V, -32768, -32768, -32768);
		send_vec(AXIS_W, -32768, 32767, -32768);
		send_vec(AXIS_U, -32768, 0, 0);
		send_vec(AXIS_V, 32767, 1, 0);
		send_vec(AXIS_W, 32767, 0, 300);
		send_vec(AXIS_X, 1, -1, 1);
		send_vec(AXIS_U, 0, -32768, 0);
		send_vec(AXIS_X, 0, 0, 0);

		// highest threshold: nearly every vector falls back, a y vector does not
		write_thr(16'hFFFF);
		send_vec(AXIS_U, 0, 500, 0);
		send_vec(AXIS_V, 0, -32768, 0);
		send_vec(AXIS_W, 0, 7, 0);
		send_vec(AXIS_U, 3, 4, 5);
		random_phase(350);

		// zero threshold: never falls back
		write_thr(16'h0000);
		send_vec(AXIS_U, 32767, 0, 0);
		send_vec(AXIS_W, -5, 0, 0);
		random_phase(350);

		write_thr(16'($urandom_range(1, 65534)));
		random_phase(330);

		write_thr(THR_RESET);
		random_phase(330);

		drain();
		$display("Sent %0d vectors over %0d threshold writes, including zero,",
			n_items, n_thr);
		$display("full-scale, axis-aligned and near-x inputs on all selectors.");
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
